// ===== hw/rtl/p2n_pkg.sv =====
// Package for the pitch to note converter.
// Holds field widths, curve constants and the controller/datapath interface types.
// No dependencies.
package p2n_pkg;

  localparam int unsigned PitchW = 16;
  localparam int unsigned NoteW  = 16;
  localparam int unsigned FineW  = 16;
  localparam int unsigned OutW   = 26;

  localparam int unsigned OctW   = 4;
  localparam int unsigned CurveW = 14;
  localparam int unsigned SpanW  = 30;
  localparam int unsigned WidthW = SpanW - 5;
  localparam int unsigned StepW  = 6;
  localparam int unsigned BinW   = 5;
  localparam int unsigned BitSelW = 3;
  localparam int unsigned IdxW   = 11;
  localparam int unsigned NoteSumW = OutW - 8;
  localparam int unsigned FineSumW = FineW + 1;

  localparam logic [CurveW-1:0]   CurveOne   = 14'h1000;
  localparam logic [CurveW-1:0]   CurveMul   = 14'h103B;
  localparam logic [StepW-1:0]    LastStep   = 6'd47;
  localparam logic [IdxW-1:0]     MissIndex  = 11'h600;
  localparam logic [BitSelW-1:0]  TopBinBit  = 3'd4;
  localparam logic [NoteSumW-1:0] OctaveNotes = 18'd12;
  localparam logic [NoteSumW-1:0] CenterOffset = 18'd144;

  typedef struct packed {
    logic               load;
    logic               step;
    logic               hit;
    logic               miss;
    logic               probe;
    logic [BitSelW-1:0] probe_bit;
    logic               out_load;
  } p2n_cmd_t;

  typedef struct packed {
    logic match;
    logic last_step;
  } p2n_sts_t;

endpackage

// ===== hw/rtl/p2n_ctrl.sv =====
// Controller state machine of the pitch to note converter.
// Depends on p2n_pkg; drives the datapath commands and both handshakes.
module p2n_ctrl import p2n_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  p2n_sts_t sts_i,
  output p2n_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_STEP   = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_FINISH = 4'b1000
  } p2n_state_e;

  p2n_state_e         state_q, state_d;
  logic [BitSelW-1:0] bit_q, bit_d;
  logic               out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    bit_d       = bit_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.probe_bit = bit_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        if (sts_i.match) begin
          cmd_o.hit = 1'b1;
          bit_d     = TopBinBit;
          state_d   = ST_SEARCH;
        end else if (sts_i.last_step) begin
          cmd_o.miss = 1'b1;
          state_d    = ST_FINISH;
        end
      end
      ST_SEARCH: begin
        cmd_o.probe = 1'b1;
        if (bit_q == '0) begin
          state_d = ST_FINISH;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/p2n_datapath.sv =====
// Datapath of the pitch to note converter: octave encoder, curve walk,
// bin search and result packing. Depends on p2n_pkg; driven by p2n_ctrl.
module p2n_datapath import p2n_pkg::*; (
  input  logic                   clk_i,
  input  p2n_cmd_t               cmd_i,
  output p2n_sts_t               sts_o,
  input  logic [NoteW-1:0]       center_note_i,
  input  logic [FineW-1:0]       center_fine_i,
  input  logic [PitchW-1:0]      pitch_i,
  output logic signed [OutW-1:0] note_and_fine_o
);

  function automatic logic [OctW-1:0] top_bit(input logic [PitchW-1:0] p);
    logic [OctW-1:0] b;
    b = '0;
    for (int i = 1; i < PitchW; i++) begin
      if (p[i]) begin
        b = OctW'(i);
      end
    end
    return b;
  endfunction

  logic [NoteW-1:0]  cnote_q;
  logic [FineW-1:0]  cfine_q;
  logic [PitchW-1:0] pitch_q;
  logic [OctW-1:0]   oct_q;
  logic [CurveW-1:0] curve_q, curve_nx_q, curve_nx_d;
  logic [StepW-1:0]  step_q;
  logic [SpanW-1:0]  lower_q;
  logic [WidthW-1:0] width_q;
  logic [IdxW-1:0]   idx_q;
  logic [OutW-1:0]   result_q, result_d;

  logic [2*CurveW-1:0] curve_prod;
  logic [SpanW-1:0]    lower, upper, span, top, pitch_hi, probe_val;
  logic [WidthW-1:0]   width;
  logic [BinW-1:0]     trial;
  logic                probe_ok;
  logic [NoteSumW-1:0] note_sum;
  logic [FineSumW-1:0] fine_sum;

  // Bin bounds are compared unshifted: floor(x / 4096) <= p holds exactly
  // when x < (p + 1) * 4096.
  assign pitch_hi = SpanW'({pitch_q, 12'h000}) + SpanW'(32'h1000);

  assign lower = SpanW'(curve_q) << oct_q;
  assign upper = SpanW'(curve_nx_q) << oct_q;
  assign span  = upper - lower;
  assign width = span[SpanW-1:5];
  assign top   = lower + {width, 5'b00000};

  assign sts_o.match     = (lower < pitch_hi) && (pitch_hi <= top);
  assign sts_o.last_step = (step_q == LastStep);

  assign curve_prod = curve_nx_q * CurveMul;
  assign curve_nx_d = curve_prod[CurveW+11:12];

  assign trial     = idx_q[BinW-1:0] | (BinW'(1) << cmd_i.probe_bit);
  assign probe_val = lower_q + SpanW'(trial) * SpanW'(width_q);
  assign probe_ok  = probe_val < pitch_hi;

  assign note_sum = NoteSumW'(cnote_q) + NoteSumW'(idx_q[IdxW-1:7])
                  + NoteSumW'(oct_q) * OctaveNotes - CenterOffset;
  assign fine_sum = FineSumW'(cfine_q) + FineSumW'(idx_q[6:0]);
  assign result_d = {note_sum, 8'h00} | OutW'(fine_sum);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cnote_q    <= center_note_i;
      cfine_q    <= center_fine_i;
      pitch_q    <= pitch_i;
      oct_q      <= top_bit(pitch_i);
      curve_q    <= CurveOne;
      curve_nx_q <= CurveMul;
      step_q     <= '0;
    end else if (cmd_i.step && !sts_o.match) begin
      curve_q    <= curve_nx_q;
      curve_nx_q <= curve_nx_d;
      step_q     <= step_q + 1'b1;
    end
    if (cmd_i.hit) begin
      lower_q <= lower;
      width_q <= width;
      idx_q   <= {step_q, {BinW{1'b0}}};
    end else if (cmd_i.miss) begin
      idx_q <= MissIndex;
    end else if (cmd_i.probe && probe_ok) begin
      idx_q[BinW-1:0] <= trial;
    end
    if (cmd_i.out_load) begin
      result_q <= result_d;
    end
  end

  assign note_and_fine_o = $signed(result_q);

endmodule

// ===== hw/rtl/pitch_to_note_convert.sv =====
// Pitch to note converter: maps a 4.12 sample pitch to a packed note and fine
// value relative to a center note and fine tuning.
// Input channel: in_valid_i/in_ready_o with center_note_i, center_fine_i and
// pitch_i; one word is taken whenever the block is idle.
// Output channel: out_valid_o/out_ready_i with note_and_fine_o, a 26-bit
// two's complement value held in an output register.
// The octave comes from the highest set pitch bit. The curve is walked one
// step per cycle on a 14 by 14 multiplier. Once the step holding the
// pitch is found, a binary search over its 32 bins settles one bin bit per probe.
// From accept to out_valid_o a word passes the curve walk, the bin search when
// the pitch falls in curve step s (0 to 47), and the finish state; a pitch
// that falls in no bin skips the search. The next input word can be taken in
// the cycle after the result is loaded, not while a word is in flight.
// The output register decouples the sides: a new word is accepted while the
// previous result still waits. If the receiver still stalls when the next result
// is finished, that result waits in the controller until the register frees up.
// Reset clears the controller and the output valid; no word is in flight.
module pitch_to_note_convert import p2n_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [NoteW-1:0]       center_note_i,
  input  logic [FineW-1:0]       center_fine_i,
  input  logic [PitchW-1:0]      pitch_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [OutW-1:0] note_and_fine_o
);

  p2n_cmd_t cmd;
  p2n_sts_t sts;

  p2n_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  p2n_datapath u_datapath (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .center_note_i  (center_note_i),
    .center_fine_i  (center_fine_i),
    .pitch_i        (pitch_i),
    .note_and_fine_o(note_and_fine_o)
  );

endmodule
